[sv/kmp_pkg.sv]
// shared types and constants for the k-medoids core
package kmp_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int DIST_BITS   = 16;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_BINIT,
    ST_BCAND,
    ST_BACC,
    ST_BNEXT,
    ST_BUPD,
    ST_BUPDW,
    ST_RINIT,
    ST_RACC,
    ST_RNEXT,
    ST_SCAND,
    ST_SACC,
    ST_SNEXT,
    ST_SAPPLY,
    ST_OINIT,
    ST_OACC,
    ST_OEMIT,
    ST_OSUM
  } kmp_state_e;

  localparam logic CFG_SAMPLE_COUNT  = 1'b0;
  localparam logic CFG_CLUSTER_COUNT = 1'b1;

endpackage

[sv/kmp_dist_mem.sv]
// distance matrix memory, one write and one registered read per cycle
module kmp_dist_mem #(
  parameter int AW = 12,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/kmp_near_mem.sv]
// per-sample nearest and second-nearest medoid distance memory
module kmp_near_mem #(
  parameter int AW = 6,
  parameter int DW = 17
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wnear_i,
  input  logic [DW-1:0] wsec_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rnear_o,
  output logic [DW-1:0] rsec_o
);

  logic [2*DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wsec_i, wnear_i};
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    {rsec_o, rnear_o} <= mem[raddr_i];
  end

endmodule

[sv/k_medoids_pam_clustering_core.sv]
// PAM k-medoids core: matrix load, build, swap and result stream
//
//  channel   dir  handshake                 word
//  s_axis    in   s_axis_tvalid/tready      {distance,col,row}, tlast = last
//  m_axis    out  m_axis_tvalid/tready      {cost,med,near,clus,idx}, tlast
//  cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// Load takes one word per cycle into the distance memory port while no result word is held.
// After the last word the block runs build and swap from the distance memory,
// then streams the results; the result stream also waits on output stalls.
// Reset clears control and flags; the distance memory is not cleared.
// Input is stalled while clustering and while results drain.
module k_medoids_pam_clustering_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // row_index[5:0], col_index[11:6], distance[27:12], zero pad
  input  logic [31:0]          s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // sample_index[5:0], cluster_index[11:6], nearest_distance[27:12],
  // is_medoid[28], total_cost[50:29], zero pad
  output logic [55:0]          m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [6:0]           cfg_data_i
);
  import kmp_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int AW = 2 * IW;
  localparam int SW = DIST_BITS + 1;
  localparam int CW = 23;
  localparam int NW = $clog2(MAX_SAMPLES + 1);
  localparam logic [SW-1:0] SENT = {1'b1, {DIST_BITS{1'b0}}};

  kmp_state_e st_q, st_d;
  logic [6:0] ncfg_q, kcfg_q;
  logic [NW-1:0] n_q, n_d, k_q, k_d, step_q, step_d;
  logic [NW-1:0] c_q, c_d, m_q, m_d, j_q, j_d;
  logic [MAX_SAMPLES-1:0] flag_q, flag_d;
  logic first_q, first_d;
  logic [CW-1:0] g_q, g_d, best_q, best_d, cost_q, cost_d;
  logic signed [CW:0] dz_q, dz_d, bdz_q, bdz_d;
  logic [NW-1:0] pick_q, pick_d, hb_q, hb_d, mb_q, mb_d;
  logic pickv_q, pickv_d;
  logic [SW-1:0] a_q, a_d, b_q, b_d;
  logic [DIST_BITS-1:0] dm_q, dm_d, bd_q, bd_d;
  logic [IW-1:0] rk_q, rk_d, bc_q, bc_d;
  logic bcv_q, bcv_d;
  logic [2:0] ph_q, ph_d;

  // memory ports
  logic dwe;
  logic [AW-1:0] dwa, dra;
  logic [DIST_BITS-1:0] dwd, drd;
  logic nwe;
  logic [IW-1:0] nwa, nra;
  logic [SW-1:0] nwn, nws, nrn, nrs;

  logic [5:0] in_row, in_col;
  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];

  kmp_dist_mem #(.AW(AW), .DW(DIST_BITS)) u_dist (
    .clk_i, .we_i(dwe), .waddr_i(dwa), .wdata_i(dwd), .raddr_i(dra), .rdata_o(drd)
  );
  kmp_near_mem #(.AW(IW), .DW(SW)) u_near (
    .clk_i, .we_i(nwe), .waddr_i(nwa), .wnear_i(nwn), .wsec_i(nws),
    .raddr_i(nra), .rnear_o(nrn), .rsec_o(nrs)
  );

  // output register
  logic ov_q, ov_d;
  logic [55:0] od_q, od_d;
  logic ol_q, ol_d;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign cfg_ready_o   = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncfg_q <= 7'd64;
      kcfg_q <= 7'd2;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SAMPLE_COUNT) ncfg_q <= cfg_data_i;
      else kcfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD;
      flag_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      flag_q <= flag_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; k_q <= k_d; step_q <= step_d; c_q <= c_d; m_q <= m_d; j_q <= j_d;
    first_q <= first_d; g_q <= g_d; best_q <= best_d; cost_q <= cost_d;
    dz_q <= dz_d; bdz_q <= bdz_d; pick_q <= pick_d; hb_q <= hb_d; mb_q <= mb_d;
    pickv_q <= pickv_d; a_q <= a_d; b_q <= b_d; dm_q <= dm_d; bd_q <= bd_d;
    rk_q <= rk_d; bc_q <= bc_d; bcv_q <= bcv_d; ph_q <= ph_d;
    od_q <= od_d; ol_q <= ol_d;
  end

  // helpers
  function automatic logic [AW-1:0] addr(input logic [NW-1:0] r, input logic [NW-1:0] c);
    addr = {r[IW-1:0], c[IW-1:0]};
  endfunction

  logic [SW-1:0] dx;
  logic signed [CW:0] dd0, ddh, dd1, dmin;
  assign dx = {1'b0, drd};

  // sequencer
  always_comb begin
    st_d = st_q; flag_d = flag_q; ov_d = ov_q; od_d = od_q; ol_d = ol_q;
    n_d = n_q; k_d = k_q; step_d = step_q; c_d = c_q; m_d = m_q; j_d = j_q;
    first_d = first_q; g_d = g_q; best_d = best_q; cost_d = cost_q;
    dz_d = dz_q; bdz_d = bdz_q; pick_d = pick_q; hb_d = hb_q; mb_d = mb_q;
    pickv_d = pickv_q; a_d = a_q; b_d = b_q; dm_d = dm_q; bd_d = bd_q;
    rk_d = rk_q; bc_d = bc_q; bcv_d = bcv_q; ph_d = ph_q;
    dwe = 1'b0; dwa = {in_row[IW-1:0], in_col[IW-1:0]};
    dwd = s_axis_tdata[12 +: DIST_BITS];
    dra = '0; nwe = 1'b0; nwa = j_q[IW-1:0]; nwn = SENT; nws = SENT;
    nra = j_q[IW-1:0];
    s_axis_tready = 1'b0;
    dd0 = '0; ddh = '0; dd1 = '0; dmin = '0;
    if (m_axis_tready) ov_d = 1'b0;

    case (st_q)
      ST_LOAD: begin
        s_axis_tready = !ov_q;
        if (s_axis_tvalid && !ov_q) begin
          dwe = (in_row < MAX_SAMPLES) && (in_col < MAX_SAMPLES);
          if (s_axis_tlast) begin
            if (ncfg_q < 7'd2) n_d = NW'(2);
            else if (ncfg_q > 7'(MAX_SAMPLES)) n_d = NW'(MAX_SAMPLES);
            else n_d = NW'(ncfg_q);
            st_d = ST_BINIT;
            j_d = '0;
          end
        end
      end
      // clear near store and flags
      ST_BINIT: begin
        if (j_q == '0) begin
          if (kcfg_q < 7'd1) k_d = NW'(1);
          else if ({1'b0, kcfg_q} > 8'(n_q)) k_d = n_q;
          else k_d = NW'(kcfg_q);
          flag_d = '0;
        end
        nwe = 1'b1;
        if (j_q == NW'(n_q - 1)) begin
          st_d = ST_BCAND; step_d = '0; c_d = '0; best_d = '0; pickv_d = 1'b0;
        end else j_d = j_q + 1'b1;
      end
      // candidate c: gain over all j
      ST_BCAND: begin
        if (c_q == n_q) begin
          st_d = ST_BUPD; j_d = '0; ph_d = '0;
        end else if (flag_q[c_q[IW-1:0]]) begin
          c_d = c_q + 1'b1;
        end else begin
          j_d = '0; g_d = '0; st_d = ST_BACC; ph_d = '0;
        end
      end
      ST_BACC: begin
        // pipelined: issue read at j, consume at j-1
        dra = addr(j_q, c_q); nra = j_q[IW-1:0];
        if (ph_q != 0) begin
          if (nrn > dx) g_d = g_q + CW'(nrn - dx);
        end
        ph_d = 3'd1;
        if (j_q == n_q) st_d = ST_BNEXT;
        else j_d = j_q + 1'b1;
      end
      ST_BNEXT: begin
        if (best_q <= g_q) begin
          best_d = g_q; pick_d = c_q; pickv_d = 1'b1;
        end
        c_d = c_q + 1'b1; st_d = ST_BCAND;
      end
      // apply pick to nearest store
      ST_BUPD: begin
        if (!pickv_q) begin
          st_d = ST_RINIT; j_d = '0;
        end else begin
          if (ph_q == 0) flag_d[pick_q[IW-1:0]] = 1'b1;
          dra = addr(j_q, pick_q); nra = j_q[IW-1:0];
          ph_d = 3'd1;
          st_d = ST_BUPDW;
        end
      end
      ST_BUPDW: begin
        nwe = 1'b1; nwa = j_q[IW-1:0];
        nwn = (nrn > dx) ? dx : nrn; nws = SENT;
        if (j_q == NW'(n_q - 1)) begin
          if (step_q == NW'(k_q - 1)) begin
            st_d = ST_RINIT; j_d = '0;
          end else begin
            step_d = step_q + 1'b1; c_d = '0; best_d = '0; pickv_d = 1'b0;
            st_d = ST_BCAND;
          end
        end else begin
          j_d = j_q + 1'b1; st_d = ST_BUPD;
        end
      end
      // refresh two-nearest for sample j
      ST_RINIT: begin
        m_d = '0; a_d = SENT; b_d = SENT; st_d = ST_RACC; ph_d = '0;
      end
      ST_RACC: begin
        dra = addr(j_q, m_q);
        if (ph_q != 0 && flag_q[IW'(m_q - 1'b1)]) begin
          if (dx < a_q) begin b_d = a_q; a_d = dx; end
          else if (dx < b_q) b_d = dx;
        end
        ph_d = 3'd1;
        if (m_q == n_q) st_d = ST_RNEXT;
        else m_d = m_q + 1'b1;
      end
      ST_RNEXT: begin
        nwe = 1'b1; nwa = j_q[IW-1:0]; nwn = a_q; nws = b_q;
        if (j_q == NW'(n_q - 1)) begin
          c_d = '0; m_d = '0; bdz_d = 'sd1; st_d = ST_SCAND;
        end else begin
          j_d = j_q + 1'b1; st_d = ST_RINIT;
        end
      end
      // swap candidates: h = c_q outer, m_q inner
      ST_SCAND: begin
        if (c_q == n_q) st_d = ST_SAPPLY;
        else if (flag_q[c_q[IW-1:0]] || m_q == n_q) begin
          c_d = c_q + 1'b1; m_d = '0;
        end else if (!flag_q[m_q[IW-1:0]]) begin
          m_d = m_q + 1'b1;
        end else begin
          j_d = '0; dz_d = '0; ph_d = '0; st_d = ST_SACC;
        end
      end
      // per j: read d(j,m), then d(j,h) with near data
      ST_SACC: begin
        nra = j_q[IW-1:0];
        case (ph_q)
          3'd0: begin dra = addr(j_q, m_q); ph_d = 3'd1; end
          3'd1: begin dm_d = drd; dra = addr(j_q, c_q); ph_d = 3'd2; end
          default: begin
            dd0 = (CW+1)'(nrn); ddh = (CW+1)'(dx); dd1 = (CW+1)'(nrs);
            if ({1'b0, dm_q} == nrn) begin
              dmin = (ddh < dd1) ? ddh : dd1;
              dz_d = dz_q + dmin - dd0;
            end else if (ddh < dd0) dz_d = dz_q + ddh - dd0;
            ph_d = '0;
            if (j_q == NW'(n_q - 1)) st_d = ST_SNEXT;
            else begin
              j_d = j_q + 1'b1;
              dra = addr(j_q + 1'b1, m_q); ph_d = 3'd1;
            end
          end
        endcase
      end
      ST_SNEXT: begin
        if (dz_q < bdz_q) begin bdz_d = dz_q; hb_d = c_q; mb_d = m_q; end
        m_d = m_q + 1'b1; st_d = ST_SCAND;
      end
      ST_SAPPLY: begin
        if (bdz_q < 0) begin
          flag_d[hb_q[IW-1:0]] = 1'b1; flag_d[mb_q[IW-1:0]] = 1'b0;
          j_d = '0; st_d = ST_RINIT;
        end else begin
          j_d = '0; cost_d = '0; ph_d = '0; st_d = ST_OINIT;
        end
      end
      // output: first pass sums cost, second pass emits
      ST_OINIT: begin
        m_d = '0; rk_d = '0; bcv_d = 1'b0; bd_d = '0; bc_d = '0;
        st_d = ST_OACC; first_d = 1'b1;
      end
      ST_OACC: begin
        dra = addr(j_q, m_q);
        if (!first_q && flag_q[IW'(m_q - 1'b1)]) begin
          if (!bcv_q || drd < bd_q) begin bd_d = drd; bc_d = rk_q; bcv_d = 1'b1; end
          rk_d = rk_q + 1'b1;
        end
        first_d = 1'b0;
        if (m_q == n_q) st_d = (ph_q == 0) ? ST_OSUM : ST_OEMIT;
        else m_d = m_q + 1'b1;
      end
      ST_OSUM: begin
        cost_d = cost_q + CW'(bd_q);
        if (j_q == NW'(n_q - 1)) begin ph_d = 3'd1; j_d = '0; end
        else j_d = j_q + 1'b1;
        st_d = ST_OINIT;
      end
      ST_OEMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          od_d = '0;
          od_d[5:0] = 6'(j_q);
          od_d[11:6] = 6'(bc_q);
          od_d[27:12] = 16'(bd_q);
          od_d[28] = flag_q[j_q[IW-1:0]];
          od_d[50:29] = cost_q[21:0];
          ol_d = (j_q == NW'(n_q - 1));
          if (j_q == NW'(n_q - 1)) st_d = ST_LOAD;
          else begin j_d = j_q + 1'b1; st_d = ST_OINIT; end
        end
      end
      default: st_d = ST_LOAD;
    endcase
  end

endmodule

[dv/k_medoids_pam_clustering_core_test.sv]
// testbench for the k-medoids core: matrix loads, clustering results against a local PAM model
module k_medoids_pam_clustering_core_test;
  import kmp_pkg::*;

  localparam int NMAX      = 64;
  localparam int SENT      = 65536;
  localparam int SILENT_MAX = 20000;

  typedef struct {
    logic [5:0]  sample;
    logic [5:0]  cluster;
    logic [15:0] near_dist;
    logic        medoid;
    logic [21:0] cost;
    logic        last;
  } sample_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_SAMPLE_COUNT;
  logic [6:0]  cfg_data_i = '0;

  k_medoids_pam_clustering_core uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // model state
  logic [15:0] dmat [0:NMAX*NMAX-1];
  int          near_d [0:NMAX-1];
  int          second_d [0:NMAX-1];
  bit          is_med [0:NMAX-1];
  logic [6:0]  samples_reg = 7'd64;
  logic [6:0]  clusters_reg = 7'd2;

  // expected results enter at the front and leave at the back
  sample_result_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  int silent_cycles = 0;
  int stall_mode = 0;
  int stall_span = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int dm(int j, int m);
    return int'(dmat[j*NMAX + m]);
  endfunction

  function automatic void refresh_two(int n);
    int a, b, d;
    for (int j = 0; j < n; j++) begin
      a = SENT;
      b = SENT;
      for (int m = 0; m < n; m++) begin
        if (!is_med[m]) continue;
        d = dm(j, m);
        if (d < a) begin
          b = a;
          a = d;
        end else if (d < b) begin
          b = d;
        end
      end
      near_d[j] = a;
      second_d[j] = b;
    end
  endfunction

  // greedy build, then best-swap descent, then one result per sample
  function automatic void predict_clustering();
    int n, k, pick, d, r, bc, bd, hb, mb;
    longint gain, best_gain, dz, best, d0, dh, d1;
    longint cost;
    int rank [0:NMAX-1];
    int bdist [0:NMAX-1];
    int bclus [0:NMAX-1];
    sample_result_t res;
    n = int'(samples_reg);
    if (n < 2) n = 2;
    if (n > NMAX) n = NMAX;
    k = int'(clusters_reg);
    if (k < 1) k = 1;
    if (k > n) k = n;
    for (int j = 0; j < NMAX; j++) begin
      near_d[j] = SENT;
      second_d[j] = SENT;
      is_med[j] = 0;
    end
    // build phase, ties to the later candidate
    for (int step = 0; step < k; step++) begin
      best_gain = 0;
      pick = -1;
      for (int c = 0; c < n; c++) begin
        if (is_med[c]) continue;
        gain = 0;
        for (int j = 0; j < n; j++) begin
          d = dm(j, c);
          if (near_d[j] > d) gain += near_d[j] - d;
        end
        if (best_gain <= gain) begin
          best_gain = gain;
          pick = c;
        end
      end
      if (pick < 0) break;
      is_med[pick] = 1;
      for (int j = 0; j < n; j++) begin
        d = dm(j, pick);
        if (near_d[j] > d) near_d[j] = d;
      end
    end
    // swap phase while cost strictly drops
    forever begin
      best = 1;
      hb = -1;
      mb = -1;
      refresh_two(n);
      for (int h = 0; h < n; h++) begin
        if (is_med[h]) continue;
        for (int m = 0; m < n; m++) begin
          if (!is_med[m]) continue;
          dz = 0;
          for (int j = 0; j < n; j++) begin
            d0 = near_d[j];
            dh = dm(j, h);
            if (dm(j, m) == d0) begin
              d1 = second_d[j];
              dz += ((dh < d1) ? dh : d1) - d0;
            end else if (dh < d0) begin
              dz += dh - d0;
            end
          end
          if (dz < best) begin
            best = dz;
            hb = h;
            mb = m;
          end
        end
      end
      if (best < 0 && hb >= 0) begin
        is_med[hb] = 1;
        is_med[mb] = 0;
      end else begin
        break;
      end
    end
    r = 0;
    for (int m = 0; m < n; m++) begin
      if (is_med[m]) begin
        rank[m] = r;
        r++;
      end else begin
        rank[m] = 0;
      end
    end
    cost = 0;
    for (int j = 0; j < n; j++) begin
      bd = 0;
      bc = -1;
      for (int m = 0; m < n; m++) begin
        if (!is_med[m]) continue;
        d = dm(j, m);
        if (bc < 0 || d < bd) begin
          bd = d;
          bc = rank[m];
        end
      end
      if (bc < 0) bc = 0;
      bdist[j] = bd;
      bclus[j] = bc;
      cost += bd;
    end
    for (int j = 0; j < n; j++) begin
      res.sample = 6'(j);
      res.cluster = 6'(bclus[j]);
      res.near_dist = 16'(bdist[j]);
      res.medoid = is_med[j];
      res.cost = 22'(cost);
      res.last = (j == n - 1);
      pending_results.push_front(res);
    end
  endfunction

  // send one matrix word; caller stands at a rising edge
  task automatic send_entry(int row, int col, int dist_val, bit last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, 16'(dist_val), 6'(col), 6'(row)};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    dmat[row*NMAX + col] = 16'(dist_val);
    items_sent++;
    if (last) predict_clustering();
  endtask

  // hold input until every expected result is out and the core is back in load
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 7'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SAMPLE_COUNT) samples_reg = 7'(value);
    else clusters_reg = 7'(value);
    @(posedge clk_i);
  endtask

  function automatic int pick_distance(int style);
    case (style)
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 3);
      2: return ($urandom_range(0, 1) != 0) ? 65535 : 0;
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  // load an n-by-n matrix in shuffled order with optional noise rows; last word starts clustering
  task automatic load_matrix(int n, int style, bit noise);
    int cells [$];
    int t, p, pos;
    for (int i = 0; i < n*n; i++) cells.push_front(i);
    for (int i = n*n - 1; i > 0; i--) begin
      p = $urandom_range(0, i);
      t = cells[i];
      cells[i] = cells[p];
      cells[p] = t;
    end
    for (int i = 0; i < n*n; i++) begin
      if (noise && n < NMAX && $urandom_range(0, 7) == 0) begin
        send_entry($urandom_range(n, NMAX - 1), $urandom_range(0, NMAX - 1),
                   pick_distance(0), 1'b0);
      end
      pos = cells[i];
      send_entry(pos / n, pos % n, pick_distance(style), i == n*n - 1);
    end
  endtask

  task automatic test_directed();
    // two samples, one medoid, distance extremes
    write_reg(CFG_SAMPLE_COUNT, 2);
    write_reg(CFG_CLUSTER_COUNT, 1);
    send_entry(0, 0, 0, 1'b0);
    send_entry(0, 1, 65535, 1'b0);
    send_entry(1, 0, 65535, 1'b0);
    send_entry(1, 1, 0, 1'b1);
    drain();
    // every sample a medoid, all distances equal
    write_reg(CFG_SAMPLE_COUNT, 3);
    write_reg(CFG_CLUSTER_COUNT, 3);
    for (int i = 0; i < 9; i++) send_entry(i / 3, i % 3, 7, i == 8);
    drain();
    // counts below range saturate to two samples, one medoid; rewrite one entry
    write_reg(CFG_SAMPLE_COUNT, 0);
    write_reg(CFG_CLUSTER_COUNT, 0);
    send_entry(1, 0, 3, 1'b1);
    drain();
    write_reg(CFG_SAMPLE_COUNT, 1);
    write_reg(CFG_CLUSTER_COUNT, 5);
    send_entry(0, 1, 3, 1'b1);
    drain();
  endtask

  task automatic test_random_runs();
    int n;
    while (items_sent < 175) begin
      n = $urandom_range(2, 6);
      if ($urandom_range(0, 5) == 0) write_reg(CFG_SAMPLE_COUNT, (n == 2) ? 1 : n);
      else write_reg(CFG_SAMPLE_COUNT, n);
      case ($urandom_range(0, 5))
        0: write_reg(CFG_CLUSTER_COUNT, 0);
        1: write_reg(CFG_CLUSTER_COUNT, 127);
        default: write_reg(CFG_CLUSTER_COUNT, $urandom_range(1, n));
      endcase
      load_matrix(n, $urandom_range(0, 3), 1'b1);
      drain();
    end
  endtask

  // larger matrix of twelve samples
  task automatic test_full_matrix();
    write_reg(CFG_SAMPLE_COUNT, 12);
    write_reg(CFG_CLUSTER_COUNT, 3);
    load_matrix(12, 0, 1'b0);
    drain();
  endtask

  task automatic test_saturated_counts();
    // twelve-by-twelve block is written, so one word is enough to start a run
    write_reg(CFG_SAMPLE_COUNT, 12);
    write_reg(CFG_CLUSTER_COUNT, 127);
    send_entry(11, 11, 65535, 1'b1);
    drain();
    write_reg(CFG_CLUSTER_COUNT, 11);
    send_entry(0, 11, 1, 1'b1);
    drain();
  endtask

  function automatic void check_result(logic [55:0] data, logic last);
    sample_result_t exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, data);
      errors++;
      return;
    end
    exp_r = pending_results.pop_back();
    if (data[5:0] !== exp_r.sample) begin
      $display("%0t: sample_index exp %0d got %0d", $time, exp_r.sample, data[5:0]);
      errors++;
    end
    if (data[11:6] !== exp_r.cluster) begin
      $display("%0t: cluster_index exp %0d got %0d", $time, exp_r.cluster, data[11:6]);
      errors++;
    end
    if (data[27:12] !== exp_r.near_dist) begin
      $display("%0t: nearest_distance exp %0d got %0d", $time, exp_r.near_dist,
               data[27:12]);
      errors++;
    end
    if (data[28] !== exp_r.medoid) begin
      $display("%0t: is_medoid exp %0d got %0d", $time, exp_r.medoid, data[28]);
      errors++;
    end
    if (data[50:29] !== exp_r.cost) begin
      $display("%0t: total_cost exp %0d got %0d", $time, exp_r.cost, data[50:29]);
      errors++;
    end
    if (last !== exp_r.last) begin
      $display("%0t: last_result exp %0d got %0d", $time, exp_r.last, last);
      errors++;
    end
  endfunction

  // result checker, receiver stall pattern and watchdog
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      silent_cycles = 0;
    end else begin
      silent_cycles++;
    end
    if (silent_cycles > SILENT_MAX) begin
      $display("k_medoids_pam_clustering_core_test failed");
      $finish;
    end
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(8, 80);
    end
    stall_span--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_runs();
    test_full_matrix();
    test_saturated_counts();
    drain();
    if (errors == 0) begin
      $display("k_medoids_pam_clustering_core_test passed");
    end else begin
      $display("k_medoids_pam_clustering_core_test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/kmp_pkg.sv
sv/kmp_dist_mem.sv
sv/kmp_near_mem.sv
sv/k_medoids_pam_clustering_core.sv
dv/k_medoids_pam_clustering_core_test.sv
